FILE: rtl/mrf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrf_pkg: shared types and constants of the Muller root finder
// Operation and operand codes of the sequencer program, saturating helpers,
// configuration layout and status codes.
// ----------------------------------------------------------------------------
package mrf_pkg;

   localparam int DATA_W             = 64;
   localparam int LIMIT_W            = 8;
   localparam int CNT_W              = 9;
   localparam int RF_AW              = 4;
   localparam int PC_W               = 6;
   localparam int MAX_ITERATIONS_DEF = 255;

   localparam logic [63:0] FX_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] FX_MIN  = 64'h8000_0000_0000_0000;
   localparam logic [63:0] FX_FOUR = 64'h0000_0004_0000_0000;
   localparam logic [63:0] FX_MTWO = 64'hFFFF_FFFE_0000_0000;

   localparam logic [63:0] CUBIC_RST    = 64'h0000_0001_0000_0000;
   localparam logic [63:0] SQUARE_RST   = 64'hFFFF_FFFE_0000_0000;
   localparam logic [63:0] LINEAR_RST   = 64'h0000_0000_0000_0000;
   localparam logic [63:0] CONSTANT_RST = 64'hFFFF_FFFB_0000_0000;
   localparam logic [62:0] TOL_RST      = 63'd42950;

   typedef enum logic [2:0] {
      CSR_CUBIC    = 3'd0,
      CSR_SQUARE   = 3'd1,
      CSR_LINEAR   = 3'd2,
      CSR_CONSTANT = 3'd3,
      CSR_TOL      = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic [63:0] cubic;
      logic [63:0] square;
      logic [63:0] linear;
      logic [63:0] constant;
      logic [62:0] tolerance;
   } coef_type;

   typedef enum logic [1:0] {
      ST_CONVERGED = 2'd0,
      ST_LIMIT     = 2'd1,
      ST_FAIL      = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SQRT, OP_SEL, OP_MOV, OP_PNEW,
      OP_CHKZ, OP_CHKNEG, OP_CHKTOL, OP_NEXT
   } op_type;

   typedef enum logic [4:0] {
      R_P0 = 5'd0, R_P1 = 5'd1, R_P2 = 5'd2, R_H1 = 5'd3, R_H2 = 5'd4,
      R_HS = 5'd5, R_F0 = 5'd6, R_F1 = 5'd7, R_F2 = 5'd8, R_T = 5'd9,
      R_U = 5'd10, R_D1 = 5'd11, R_D2 = 5'd12, R_DL = 5'd13, R_B = 5'd14,
      R_DD = 5'd15,
      K_C3 = 5'd16, K_C2 = 5'd17, K_C1 = 5'd18, K_C0 = 5'd19,
      K_FOUR = 5'd20, K_MTWO = 5'd21
   } src_type;

   typedef struct packed {
      op_type  op;
      src_type a;
      src_type b;
      src_type dst;
   } instr_type;

   typedef enum logic [2:0] {
      S_IDLE, S_LOAD, S_FETCH, S_EXEC, S_OUT
   } state_type;

   function automatic logic [63:0] sat_addsub(input logic [63:0] a, input logic [63:0] b,
                                              input logic sub);
      logic [64:0] ea;
      logic [64:0] eb;
      logic [64:0] s;
      ea = {a[63], a};
      eb = {b[63], b};
      s  = sub ? (ea - eb) : (ea + eb);
      if (s[64] != s[63]) begin
         return s[64] ? FX_MIN : FX_MAX;
      end
      return s[63:0];
   endfunction

   function automatic logic [63:0] sat_abs(input logic [63:0] a);
      if (a[63]) begin
         return (a == FX_MIN) ? FX_MAX : (64'd0 - a);
      end
      return a;
   endfunction

   function automatic logic [63:0] with_sign(input logic [63:0] mag, input logic neg,
                                             input logic over);
      if (neg) begin
         if (over || mag > FX_MIN) begin
            return FX_MIN;
         end
         return 64'd0 - mag;
      end
      if (over || mag[63]) begin
         return FX_MAX;
      end
      return mag;
   endfunction

   function automatic instr_type mk(input op_type op, input src_type a, input src_type b,
                                    input src_type dst);
      instr_type ins;
      ins.op  = op;
      ins.a   = a;
      ins.b   = b;
      ins.dst = dst;
      return ins;
   endfunction

   // horner evaluation of the cubic at x
   function automatic instr_type poly_step(input logic [2:0] k, input src_type x,
                                           input src_type dst);
      instr_type ins;
      case (k)
         3'd0: ins = mk(OP_MUL, K_C3, x, R_T);
         3'd1: ins = mk(OP_ADD, R_T, K_C2, R_T);
         3'd2: ins = mk(OP_MUL, R_T, x, R_T);
         3'd3: ins = mk(OP_ADD, R_T, K_C1, R_T);
         3'd4: ins = mk(OP_MUL, R_T, x, R_T);
         default: ins = mk(OP_ADD, R_T, K_C0, dst);
      endcase
      return ins;
   endfunction

   function automatic instr_type program_at(input logic [PC_W-1:0] pc);
      instr_type ins;
      ins = mk(OP_NEXT, R_P0, R_P0, R_P0);
      if (pc >= 6'd6 && pc < 6'd12) begin
         ins = poly_step(3'(pc - 6'd6), R_P0, R_F0);
      end else if (pc >= 6'd12 && pc < 6'd18) begin
         ins = poly_step(3'(pc - 6'd12), R_P1, R_F1);
      end else if (pc >= 6'd18 && pc < 6'd24) begin
         ins = poly_step(3'(pc - 6'd18), R_P2, R_F2);
      end else begin
         case (pc)
            6'd0:  ins = mk(OP_SUB, R_P1, R_P0, R_H1);
            6'd1:  ins = mk(OP_SUB, R_P2, R_P1, R_H2);
            6'd2:  ins = mk(OP_ADD, R_H2, R_H1, R_HS);
            6'd3:  ins = mk(OP_CHKZ, R_H1, R_H1, R_P0);
            6'd4:  ins = mk(OP_CHKZ, R_H2, R_H2, R_P0);
            6'd5:  ins = mk(OP_CHKZ, R_HS, R_HS, R_P0);
            6'd24: ins = mk(OP_SUB, R_F1, R_F0, R_T);
            6'd25: ins = mk(OP_DIV, R_T, R_H1, R_D1);
            6'd26: ins = mk(OP_SUB, R_F2, R_F1, R_T);
            6'd27: ins = mk(OP_DIV, R_T, R_H2, R_D2);
            6'd28: ins = mk(OP_SUB, R_D2, R_D1, R_T);
            6'd29: ins = mk(OP_DIV, R_T, R_HS, R_DL);
            6'd30: ins = mk(OP_MUL, R_H2, R_DL, R_T);
            6'd31: ins = mk(OP_ADD, R_D2, R_T, R_B);
            6'd32: ins = mk(OP_MUL, R_B, R_B, R_U);
            6'd33: ins = mk(OP_MUL, K_FOUR, R_F2, R_T);
            6'd34: ins = mk(OP_MUL, R_T, R_DL, R_T);
            6'd35: ins = mk(OP_SUB, R_U, R_T, R_T);
            6'd36: ins = mk(OP_CHKNEG, R_T, R_T, R_P0);
            6'd37: ins = mk(OP_SQRT, R_T, R_T, R_DD);
            6'd38: ins = mk(OP_SUB, R_B, R_DD, R_T);
            6'd39: ins = mk(OP_ADD, R_B, R_DD, R_U);
            6'd40: ins = mk(OP_SEL, R_T, R_U, R_D1);
            6'd41: ins = mk(OP_CHKZ, R_D1, R_D1, R_P0);
            6'd42: ins = mk(OP_MUL, K_MTWO, R_F2, R_T);
            6'd43: ins = mk(OP_DIV, R_T, R_D1, R_D2);
            6'd44: ins = mk(OP_PNEW, R_P2, R_D2, R_U);
            6'd45: ins = mk(OP_CHKTOL, R_D2, R_D2, R_P0);
            6'd46: ins = mk(OP_MOV, R_P1, R_P1, R_P0);
            6'd47: ins = mk(OP_MOV, R_P2, R_P2, R_P1);
            6'd48: ins = mk(OP_MOV, R_U, R_U, R_P2);
            default: ins = mk(OP_NEXT, R_P0, R_P0, R_P0);
         endcase
      end
      return ins;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/mrf_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrf_req_if: request channel of the Muller root finder
// Three starting points and the iteration limit, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mrf_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] guess_first;
   logic [63:0] guess_second;
   logic [63:0] guess_third;
   logic [7:0]  iteration_limit;

   modport source (output valid, guess_first, guess_second, guess_third, iteration_limit,
                   input ready);
   modport sink (input valid, guess_first, guess_second, guess_third, iteration_limit,
                 output ready);
endinterface
`default_nettype wire

FILE: rtl/mrf_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrf_rsp_if: result channel of the Muller root finder
// Root, status and iteration count, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mrf_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] root;
   logic [1:0]  status;
   logic [7:0]  iterations_done;

   modport source (output valid, root, status, iterations_done, input ready);
   modport sink (input valid, root, status, iterations_done, output ready);
endinterface
`default_nettype wire

FILE: rtl/muller_root_finder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// muller_root_finder: Muller's method root search on a configurable cubic
// Holds the coefficient and tolerance registers and runs the iteration.
//
//   channel   kind        contents
//   req_bus   valid/ready three starting points, iteration limit
//   rsp_bus   valid/ready root, status, iterations done
//   csr_*     apb write   coefficients, tolerance (8-byte stride)
//
// after loading the three starting points, each iteration spends most of
// its time in the serial divider (four divides per iteration) and the
// square root; multiplies are shorter
// synchronous reset, no clearing pass; one request at a time
// ready is low from acceptance until the result is taken
// ----------------------------------------------------------------------------
module muller_root_finder #(
   parameter int MAX_ITERATIONS = mrf_pkg::MAX_ITERATIONS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   mrf_req_if.sink          req_bus,
   mrf_rsp_if.source        rsp_bus,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [5:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output logic [63:0]      csr_prdata,
   output logic             csr_pready
);
   import mrf_pkg::*;

   coef_type    coef_ff;
   csr_idx_type csr_idx;

   assign csr_idx    = csr_idx_type'(csr_paddr[5:3]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.cubic     <= CUBIC_RST;
         coef_ff.square    <= SQUARE_RST;
         coef_ff.linear    <= LINEAR_RST;
         coef_ff.constant  <= CONSTANT_RST;
         coef_ff.tolerance <= TOL_RST;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         case (csr_idx)
            CSR_CUBIC:    coef_ff.cubic     <= csr_pwdata;
            CSR_SQUARE:   coef_ff.square    <= csr_pwdata;
            CSR_LINEAR:   coef_ff.linear    <= csr_pwdata;
            CSR_CONSTANT: coef_ff.constant  <= csr_pwdata;
            CSR_TOL:      coef_ff.tolerance <= csr_pwdata[62:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_CUBIC:    csr_prdata = coef_ff.cubic;
         CSR_SQUARE:   csr_prdata = coef_ff.square;
         CSR_LINEAR:   csr_prdata = coef_ff.linear;
         CSR_CONSTANT: csr_prdata = coef_ff.constant;
         CSR_TOL:      csr_prdata = {1'b0, coef_ff.tolerance};
         default:      csr_prdata = 64'd0;
      endcase
   end

   mrf_core #(
      .MAX_ITERATIONS(MAX_ITERATIONS)
   ) u_core (
      .clock(clock),
      .reset(reset),
      .coef (coef_ff),
      .req  (req_bus),
      .rsp  (rsp_bus)
   );

endmodule
`default_nettype wire

FILE: rtl/mrf_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrf_core: sequencer and shared arithmetic unit
// Runs the Muller iteration as a small program over a 16-entry register
// file, with one multi-cycle unit for multiply, divide and square root.
// ----------------------------------------------------------------------------
module mrf_core #(
   parameter int MAX_ITERATIONS = mrf_pkg::MAX_ITERATIONS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mrf_pkg::coef_type coef,
   mrf_req_if.sink                req,
   mrf_rsp_if.source              rsp
);
   import mrf_pkg::*;

   localparam logic [15:0] MAX_LIMIT = 16'(MAX_ITERATIONS);

   state_type            state_ff, state_in;
   logic [PC_W-1:0]      pc_ff;
   logic [6:0]           cnt_ff;
   logic [CNT_W-1:0]     i_ff;
   logic [15:0]          limit_ff;
   logic [63:0]          root_ff;
   status_type           status_ff;
   logic [63:0]          g0_ff, g1_ff, g2_ff;

   logic [63:0]          rf_mem [2**RF_AW];
   logic [63:0]          rd_a_ff, rd_b_ff;

   logic [63:0]          ma_ff, mb_ff;
   logic                 neg_ff;
   logic [127:0]         acc_ff;
   logic [63:0]          pp_ff;
   logic [1:0]           pp_sh_ff;
   logic [95:0]          work_ff;
   logic [65:0]          rem_ff;
   logic [63:0]          quo_ff;
   logic                 over_ff;

   instr_type            ins;
   logic [63:0]          opa, opb, addsub, abs_a, abs_b, res;
   logic [65:0]          sub_x, sub_y;
   logic [66:0]          diff;
   logic                 ge, unit_done, writes;
   logic                 accept, finish, pc_step, pc_clear, count_up;
   status_type           fin_status;
   logic [15:0]          lim_req, limit_eff;
   logic [1:0]           kk;
   logic                 wr_en;
   logic [RF_AW-1:0]     wr_addr;
   logic [63:0]          wr_data;

   function automatic logic [63:0] operand(input src_type s, input logic [63:0] rd,
                                           input coef_type c);
      case (s)
         K_C3:    return c.cubic;
         K_C2:    return c.square;
         K_C1:    return c.linear;
         K_C0:    return c.constant;
         K_FOUR:  return FX_FOUR;
         K_MTWO:  return FX_MTWO;
         default: return rd;
      endcase
   endfunction

   assign ins    = program_at(pc_ff);
   assign opa    = operand(ins.a, rd_a_ff, coef);
   assign opb    = operand(ins.b, rd_b_ff, coef);
   assign addsub = sat_addsub(opa, opb, ins.op == OP_SUB);
   assign abs_a  = sat_abs(opa);
   assign abs_b  = sat_abs(opb);
   assign accept = req.valid && req.ready;
   assign kk     = 2'(cnt_ff - 7'd1);

   assign lim_req   = {8'd0, req.iteration_limit};
   assign limit_eff = (lim_req > MAX_LIMIT) ? MAX_LIMIT : lim_req;

   always_comb begin
      if (ins.op == OP_SQRT) begin
         sub_x = {rem_ff[63:0], work_ff[95:94]};
         sub_y = {quo_ff, 2'b01};
      end else begin
         sub_x = {1'b0, rem_ff[63:0], work_ff[95]};
         sub_y = {2'b00, mb_ff};
      end
      diff = {1'b0, sub_x} - {1'b0, sub_y};
      ge   = !diff[66];
   end

   always_comb begin
      unit_done = 1'b1;
      writes    = 1'b1;
      res       = opa;
      case (ins.op)
         OP_ADD, OP_SUB, OP_PNEW: res = addsub;
         OP_MUL: begin
            unit_done = (cnt_ff == 7'd6);
            res       = with_sign(acc_ff[95:32], neg_ff, |acc_ff[127:96]);
         end
         OP_DIV: begin
            unit_done = (cnt_ff == 7'd97);
            res       = with_sign(quo_ff, neg_ff, over_ff);
         end
         OP_SQRT: begin
            unit_done = (cnt_ff == 7'd49);
            res       = quo_ff;
         end
         OP_SEL:  res = (abs_a < abs_b) ? opb : opa;
         OP_MOV:  res = opa;
         default: writes = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      finish     = 1'b0;
      fin_status = ST_LIMIT;
      pc_step    = 1'b0;
      pc_clear   = 1'b0;
      count_up   = 1'b0;
      req.ready  = (state_ff == S_IDLE);
      rsp.valid  = (state_ff == S_OUT);
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               state_in = (16'd3 > limit_eff) ? S_OUT : S_LOAD;
            end
         end
         S_LOAD: begin
            if (cnt_ff == 7'd2) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: state_in = S_EXEC;
         S_EXEC: begin
            if (unit_done) begin
               pc_step = 1'b1;
               case (ins.op)
                  OP_CHKZ: begin
                     if (opa == 64'd0) begin
                        finish     = 1'b1;
                        fin_status = ST_FAIL;
                     end
                  end
                  OP_CHKNEG: begin
                     if (opa[63]) begin
                        finish     = 1'b1;
                        fin_status = ST_FAIL;
                     end
                  end
                  OP_CHKTOL: begin
                     if (abs_a < {1'b0, coef.tolerance}) begin
                        finish     = 1'b1;
                        fin_status = ST_CONVERGED;
                     end
                  end
                  OP_NEXT: begin
                     pc_step  = 1'b0;
                     count_up = 1'b1;
                     if (({7'd0, i_ff} + 16'd1) > limit_ff) begin
                        finish = 1'b1;
                     end else begin
                        pc_clear = 1'b1;
                     end
                  end
                  default: ;
               endcase
               state_in = finish ? S_OUT : S_FETCH;
            end
         end
         S_OUT: begin
            if (rsp.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff     <= '0;
         cnt_ff    <= '0;
         i_ff      <= '0;
         status_ff <= ST_CONVERGED;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  g0_ff     <= req.guess_first;
                  g1_ff     <= req.guess_second;
                  g2_ff     <= req.guess_third;
                  root_ff   <= req.guess_third;
                  limit_ff  <= limit_eff;
                  i_ff      <= CNT_W'(3);
                  pc_ff     <= '0;
                  cnt_ff    <= '0;
                  status_ff <= ST_LIMIT;
               end
            end
            S_LOAD: cnt_ff <= (cnt_ff == 7'd2) ? 7'd0 : cnt_ff + 7'd1;
            S_FETCH: cnt_ff <= '0;
            S_EXEC: begin
               cnt_ff <= unit_done ? 7'd0 : cnt_ff + 7'd1;
               if (unit_done) begin
                  if (pc_step) begin
                     pc_ff <= pc_ff + 6'd1;
                  end
                  if (pc_clear) begin
                     pc_ff <= '0;
                  end
                  if (count_up) begin
                     i_ff <= i_ff + 9'd1;
                  end
                  if (finish) begin
                     status_ff <= fin_status;
                  end
                  if (ins.op == OP_PNEW) begin
                     root_ff <= res;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // shared multiply / divide / square root unit
   always_ff @(posedge clock) begin
      if (state_ff == S_EXEC) begin
         if (cnt_ff == 7'd0) begin
            ma_ff   <= opa[63] ? (64'd0 - opa) : opa;
            mb_ff   <= opb[63] ? (64'd0 - opb) : opb;
            neg_ff  <= opa[63] != opb[63];
            acc_ff  <= '0;
            rem_ff  <= '0;
            quo_ff  <= '0;
            over_ff <= 1'b0;
            if (ins.op == OP_SQRT) begin
               work_ff <= {opa, 32'd0};
            end else begin
               work_ff <= {opa[63] ? (64'd0 - opa) : opa, 32'd0};
            end
         end else if (ins.op == OP_MUL) begin
            if (cnt_ff <= 7'd4) begin
               pp_ff    <= (kk[1] ? ma_ff[63:32] : ma_ff[31:0]) *
                           (kk[0] ? mb_ff[63:32] : mb_ff[31:0]);
               pp_sh_ff <= {1'b0, kk[1]} + {1'b0, kk[0]};
            end
            if (cnt_ff >= 7'd2) begin
               case (pp_sh_ff)
                  2'd1:    acc_ff <= acc_ff + {32'd0, pp_ff, 32'd0};
                  2'd2:    acc_ff <= acc_ff + {pp_ff, 64'd0};
                  default: acc_ff <= acc_ff + {64'd0, pp_ff};
               endcase
            end
         end else if (ins.op == OP_DIV || ins.op == OP_SQRT) begin
            if (!unit_done) begin
               rem_ff <= ge ? diff[65:0] : sub_x;
               quo_ff <= {quo_ff[62:0], ge};
               if (ins.op == OP_SQRT) begin
                  work_ff <= {work_ff[93:0], 2'b00};
               end else begin
                  work_ff <= {work_ff[94:0], 1'b0};
                  if (ge && cnt_ff <= 7'd32) begin
                     over_ff <= 1'b1;
                  end
               end
            end
         end
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ins.dst[RF_AW-1:0];
      wr_data = res;
      if (state_ff == S_LOAD) begin
         wr_en   = 1'b1;
         wr_addr = RF_AW'(cnt_ff[1:0]);
         case (cnt_ff[1:0])
            2'd0:    wr_data = g0_ff;
            2'd1:    wr_data = g1_ff;
            default: wr_data = g2_ff;
         endcase
      end else if (state_ff == S_EXEC && unit_done && writes) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rf_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= rf_mem[ins.a[RF_AW-1:0]];
      rd_b_ff <= rf_mem[ins.b[RF_AW-1:0]];
   end

   assign rsp.root            = root_ff;
   assign rsp.status          = status_ff;
   assign rsp.iterations_done = i_ff[8] ? 8'hFF : i_ff[7:0];

endmodule
`default_nettype wire
